// File: design/swsnd_pkg.sv
`default_nettype none
package swsnd_pkg;

   localparam int WINDOW_DEPTH_DEF = 32;

   localparam int WIN_W  = 6;
   localparam int TMO_W  = 16;
   localparam int WORD_W = 32;
   localparam int OP_W   = 2;
   localparam int ACK_W  = 6;
   localparam int CSR_INDEX_W = 2;

   localparam logic [WIN_W-1:0]  WINDOW_SLOTS_RST   = WIN_W'(32);
   localparam logic [TMO_W-1:0]  TIMEOUT_TICKS_RST  = TMO_W'(2000);
   localparam logic [WORD_W-1:0] TOTAL_REQUESTS_RST = WORD_W'(1000000);

   localparam logic [WORD_W-1:0] ACK_KIND = WORD_W'(2);
   localparam logic [WORD_W-1:0] NO_SEQ   = '1;

   localparam logic [OP_W-1:0] OP_SEND = 2'd0;
   localparam logic [OP_W-1:0] OP_ACK  = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_SLOTS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL_REQUESTS = 2'd2;

   typedef struct packed {
      logic [WORD_W-1:0] total_requests;
      logic [TMO_W-1:0]  timeout_ticks;
      logic [WIN_W-1:0]  window_slots;
   } cfg_type;

   typedef struct packed {
      logic              all_done;
      logic [WORD_W-1:0] timeout_total;
      logic [WORD_W-1:0] rx_total;
      logic [WORD_W-1:0] tx_total;
      logic [WORD_W-1:0] window_next;
      logic [WORD_W-1:0] window_base;
      logic [WORD_W-1:0] timeout_end;
      logic [WORD_W-1:0] timeout_start;
      logic              timeout_fired;
      logic [ACK_W-1:0]  acked_count;
      logic [WORD_W-1:0] data_seq;
      logic              send_accepted;
   } rsp_type;

   localparam int RSP_W        = $bits(rsp_type);
   localparam int RSP_TDATA_W  = ((RSP_W + 7) / 8) * 8;
   localparam int REQ_TDATA_W  = 3 * WORD_W;
   localparam int REQ_TUSER_W  = 8;

endpackage
`default_nettype wire

// File: design/sliding_window_sender.sv
// Go-back-N sender window.
// Request channel (req_): one beat is a send request, an arrived packet or a
// millisecond tick, selected by req_tuser. Response channel (rsp_): exactly
// one beat per request beat, in order, carrying the item's outcome and the
// window status after it. Configuration (csr_): window size, timeout and
// request total, written while no request is in flight.
// Steps per request beat: a send, a refused or ignored packet and a tick on
// an empty window go straight to the done state; a tick that keeps the window
// passes the tick check first; an acknowledgement covering n slots sweeps
// those n slots; a tick that abandons n outstanding slots passes the tick
// check and then sweeps them (n at most WINDOW_DEPTH). The slot sweep visits
// one slot per cycle through the single read port of the slot memory.
// req_tready is high only while the sequencer is idle. A finished result
// sits in the output register; the next request beat is taken meanwhile,
// and its result waits in the sequencer until rsp_tready frees the register.
// Reset empties the window, clears every slot valid bit and all counters,
// and loads window 32, timeout 2000 ticks and 1000000 requests.
`default_nettype none
module sliding_window_sender #(
   parameter int WINDOW_DEPTH = swsnd_pkg::WINDOW_DEPTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // ack_kind, ack_number, ack_length
   input  wire logic [swsnd_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // operation
   input  wire logic [swsnd_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // send_accepted, data_seq, acked_count, timeout_fired, timeout_start,
   // timeout_end, window_base, window_next, tx_total, rx_total,
   // timeout_total, all_done, zero fill
   output logic      [swsnd_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  wire logic                                  csr_wr_en,
   input  wire logic [swsnd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [swsnd_pkg::WORD_W-1:0]          csr_wdata
);

   localparam int W = swsnd_pkg::WORD_W;

   swsnd_pkg::cfg_type cfg_ff;
   swsnd_pkg::rsp_type rsp_ff;
   swsnd_pkg::rsp_type core_rsp;
   logic               rsp_valid_ff;
   logic               core_valid;
   logic               core_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_slots   <= swsnd_pkg::WINDOW_SLOTS_RST;
         cfg_ff.timeout_ticks  <= swsnd_pkg::TIMEOUT_TICKS_RST;
         cfg_ff.total_requests <= swsnd_pkg::TOTAL_REQUESTS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            swsnd_pkg::CSR_WINDOW_SLOTS: begin
               cfg_ff.window_slots <= csr_wdata[swsnd_pkg::WIN_W-1:0];
            end
            swsnd_pkg::CSR_TIMEOUT_TICKS: begin
               cfg_ff.timeout_ticks <= csr_wdata[swsnd_pkg::TMO_W-1:0];
            end
            swsnd_pkg::CSR_TOTAL_REQUESTS: begin
               cfg_ff.total_requests <= csr_wdata;
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   swsnd_core #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (req_tuser[swsnd_pkg::OP_W-1:0]),
      .in_kind   (req_tdata[W-1:0]),
      .in_number (req_tdata[2*W-1:W]),
      .in_length (req_tdata[3*W-1:2*W]),
      .out_valid (core_valid),
      .out_ready (core_ready),
      .out_rsp   (core_rsp)
   );

   assign core_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_valid && core_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (core_valid && core_ready) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = swsnd_pkg::RSP_TDATA_W'(rsp_ff);

endmodule
`default_nettype wire

// File: design/swsnd_slot_store.sv
`default_nettype none
module swsnd_slot_store #(
   parameter int WINDOW_DEPTH = swsnd_pkg::WINDOW_DEPTH_DEF,
   localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          wr_en,
   input  wire logic [PTR_W-1:0]              wr_addr,
   input  wire logic [swsnd_pkg::WORD_W-1:0]  wr_seq,
   input  wire logic [swsnd_pkg::WORD_W-1:0]  wr_time,
   input  wire logic [PTR_W-1:0]              rd_addr,
   output logic      [swsnd_pkg::WORD_W-1:0]  rd_seq,
   output logic      [swsnd_pkg::WORD_W-1:0]  rd_time,
   input  wire logic                          clr_en,
   input  wire logic [PTR_W-1:0]              vld_addr,
   output logic                               vld
);

   logic [2*swsnd_pkg::WORD_W-1:0] slot_mem_ff [WINDOW_DEPTH];
   logic [2*swsnd_pkg::WORD_W-1:0] rd_data_ff;
   logic [WINDOW_DEPTH-1:0]        valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= {wr_time, wr_seq};
      end
      rd_data_ff <= slot_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end else if (clr_en) begin
            valid_ff[vld_addr] <= 1'b0;
         end
      end
   end

   assign rd_seq  = rd_data_ff[swsnd_pkg::WORD_W-1:0];
   assign rd_time = rd_data_ff[2*swsnd_pkg::WORD_W-1:swsnd_pkg::WORD_W];
   assign vld     = valid_ff[vld_addr];

endmodule
`default_nettype wire

// File: design/swsnd_core.sv
`default_nettype none
module swsnd_core #(
   parameter int WINDOW_DEPTH = swsnd_pkg::WINDOW_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire swsnd_pkg::cfg_type            cfg,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [swsnd_pkg::OP_W-1:0]    in_op,
   input  wire logic [swsnd_pkg::WORD_W-1:0]  in_kind,
   input  wire logic [swsnd_pkg::WORD_W-1:0]  in_number,
   input  wire logic [swsnd_pkg::WORD_W-1:0]  in_length,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output swsnd_pkg::rsp_type                 out_rsp
);

   localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int EFF_W = $clog2(WINDOW_DEPTH + 1);
   localparam int CMP_W = (EFF_W > swsnd_pkg::WIN_W) ? EFF_W : swsnd_pkg::WIN_W;
   localparam int ADV_W = (PTR_W + 1 > CMP_W) ? PTR_W + 1 : CMP_W;
   localparam int W     = swsnd_pkg::WORD_W;

   typedef enum logic [1:0] {ST_IDLE, ST_TICK_CHECK, ST_LOOP, ST_DONE} state_type;

   state_type                   state_ff, state_in;
   logic [W-1:0]                oldest_ff, oldest_in;
   logic [W-1:0]                upcoming_ff, upcoming_in;
   logic [PTR_W-1:0]            base_ptr_ff, base_ptr_in;
   logic [PTR_W-1:0]            next_ptr_ff, next_ptr_in;
   logic [W-1:0]                tick_ff, tick_in;
   logic [W-1:0]                sent_ff, sent_in;
   logic [W-1:0]                acked_total_ff, acked_total_in;
   logic [W-1:0]                events_ff, events_in;
   logic [W-1:0]                rec_start_ff, rec_start_in;
   logic [W-1:0]                rec_end_ff, rec_end_in;
   logic [W-1:0]                stop_ff, stop_in;
   logic                        is_tick_ff, is_tick_in;
   logic                        acc_ff, acc_in;
   logic [W-1:0]                dseq_ff, dseq_in;
   logic [swsnd_pkg::ACK_W-1:0] acked_ff, acked_in;
   logic                        fired_ff, fired_in;

   logic [CMP_W-1:0] win_ext;
   logic [CMP_W-1:0] eff;
   logic [W-1:0]     last_seq;
   logic [W-1:0]     oldest_inc;
   logic             seq_hit;
   logic             ack_ok;
   logic             wr_en;
   logic             clr_en;
   logic [PTR_W-1:0] rd_addr;
   logic [W-1:0]     rd_seq;
   logic [W-1:0]     rd_time;
   logic             vld;

   function automatic logic [PTR_W-1:0] adv_ptr(input logic [PTR_W-1:0] p,
                                                input logic [CMP_W-1:0] e);
      logic [ADV_W-1:0] n;
      n = ADV_W'(p) + ADV_W'(1);
      return (n >= ADV_W'(e)) ? '0 : n[PTR_W-1:0];
   endfunction

   swsnd_slot_store #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_slots (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (next_ptr_ff),
      .wr_seq   (upcoming_ff),
      .wr_time  (tick_ff),
      .rd_addr  (rd_addr),
      .rd_seq   (rd_seq),
      .rd_time  (rd_time),
      .clr_en   (clr_en),
      .vld_addr (base_ptr_ff),
      .vld      (vld)
   );

   assign win_ext = CMP_W'(cfg.window_slots);
   assign eff = (win_ext == '0) ? CMP_W'(1) :
                (win_ext > CMP_W'(WINDOW_DEPTH)) ? CMP_W'(WINDOW_DEPTH) : win_ext;

   assign last_seq   = (in_number >= upcoming_ff) ? upcoming_ff - W'(1) : in_number;
   assign oldest_inc = oldest_ff + W'(1);
   assign seq_hit    = vld && (rd_seq == oldest_ff);
   assign ack_ok     = (in_kind == swsnd_pkg::ACK_KIND) && (in_length == '0) &&
                       (in_number != swsnd_pkg::NO_SEQ) && (oldest_ff != upcoming_ff) &&
                       (in_number >= oldest_ff);

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_DONE);

   always_comb begin
      state_in       = state_ff;
      oldest_in      = oldest_ff;
      upcoming_in    = upcoming_ff;
      base_ptr_in    = base_ptr_ff;
      next_ptr_in    = next_ptr_ff;
      tick_in        = tick_ff;
      sent_in        = sent_ff;
      acked_total_in = acked_total_ff;
      events_in      = events_ff;
      rec_start_in   = rec_start_ff;
      rec_end_in     = rec_end_ff;
      stop_in        = stop_ff;
      is_tick_in     = is_tick_ff;
      acc_in         = acc_ff;
      dseq_in        = dseq_ff;
      acked_in       = acked_ff;
      fired_in       = fired_ff;
      wr_en          = 1'b0;
      clr_en         = 1'b0;
      rd_addr        = base_ptr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               acc_in   = 1'b0;
               dseq_in  = '0;
               acked_in = '0;
               fired_in = 1'b0;
               state_in = ST_DONE;
               case (in_op)
                  swsnd_pkg::OP_SEND: begin
                     if ((upcoming_ff < cfg.total_requests) &&
                         ((upcoming_ff - oldest_ff) < W'(eff))) begin
                        wr_en       = 1'b1;
                        acc_in      = 1'b1;
                        dseq_in     = upcoming_ff;
                        sent_in     = sent_ff + W'(1);
                        upcoming_in = upcoming_ff + W'(1);
                        next_ptr_in = adv_ptr(next_ptr_ff, eff);
                     end
                  end
                  swsnd_pkg::OP_ACK: begin
                     if (ack_ok) begin
                        stop_in    = last_seq + W'(1);
                        is_tick_in = 1'b0;
                        state_in   = ST_LOOP;
                     end
                  end
                  swsnd_pkg::OP_TICK: begin
                     tick_in = tick_ff + W'(1);
                     if (oldest_ff != upcoming_ff) begin
                        state_in = ST_TICK_CHECK;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_TICK_CHECK: begin
            if (seq_hit && ((tick_ff - rd_time) < W'(cfg.timeout_ticks))) begin
               state_in = ST_DONE;
            end else begin
               events_in    = events_ff + W'(1);
               rec_start_in = oldest_ff;
               rec_end_in   = upcoming_ff;
               fired_in     = 1'b1;
               stop_in      = upcoming_ff;
               is_tick_in   = 1'b1;
               state_in     = ST_LOOP;
            end
         end
         ST_LOOP: begin
            rd_addr     = adv_ptr(base_ptr_ff, eff);
            clr_en      = seq_hit;
            oldest_in   = oldest_inc;
            base_ptr_in = adv_ptr(base_ptr_ff, eff);
            if (!is_tick_ff) begin
               acked_in       = acked_ff + swsnd_pkg::ACK_W'(1);
               acked_total_in = acked_total_ff + W'(1);
            end
            if (oldest_inc == stop_ff) begin
               state_in = ST_DONE;
               if (is_tick_ff) begin
                  base_ptr_in = next_ptr_ff;
               end
            end
         end
         ST_DONE: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         oldest_ff      <= '0;
         upcoming_ff    <= '0;
         base_ptr_ff    <= '0;
         next_ptr_ff    <= '0;
         tick_ff        <= '0;
         sent_ff        <= '0;
         acked_total_ff <= '0;
         events_ff      <= '0;
         rec_start_ff   <= '0;
         rec_end_ff     <= '0;
         is_tick_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         oldest_ff      <= oldest_in;
         upcoming_ff    <= upcoming_in;
         base_ptr_ff    <= base_ptr_in;
         next_ptr_ff    <= next_ptr_in;
         tick_ff        <= tick_in;
         sent_ff        <= sent_in;
         acked_total_ff <= acked_total_in;
         events_ff      <= events_in;
         rec_start_ff   <= rec_start_in;
         rec_end_ff     <= rec_end_in;
         is_tick_ff     <= is_tick_in;
      end
      stop_ff  <= stop_in;
      acc_ff   <= acc_in;
      dseq_ff  <= dseq_in;
      acked_ff <= acked_in;
      fired_ff <= fired_in;
   end

   always_comb begin
      out_rsp.send_accepted = acc_ff;
      out_rsp.data_seq      = dseq_ff;
      out_rsp.acked_count   = acked_ff;
      out_rsp.timeout_fired = fired_ff;
      out_rsp.timeout_start = rec_start_ff;
      out_rsp.timeout_end   = rec_end_ff;
      out_rsp.window_base   = oldest_ff;
      out_rsp.window_next   = upcoming_ff;
      out_rsp.tx_total      = sent_ff;
      out_rsp.rx_total      = acked_total_ff;
      out_rsp.timeout_total = events_ff;
      out_rsp.all_done      = (upcoming_ff >= cfg.total_requests) &&
                              (oldest_ff == upcoming_ff);
   end

endmodule
`default_nettype wire

// File: sim/sliding_window_sender_tb.sv
`timescale 1ns / 100ps

module sliding_window_sender_tb;

   localparam int W = swsnd_pkg::WORD_W;
   localparam int DEPTH = swsnd_pkg::WINDOW_DEPTH_DEF;
   localparam int IDLE_LIMIT = 4000;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 82;
   localparam logic [swsnd_pkg::OP_W-1:0] OP_NOP = 2'd3;

   typedef enum int {FLOW_OPEN, FLOW_PATCHY, FLOW_BLOCKED} flow_mode_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   // ack_kind, ack_number, ack_length
   logic [swsnd_pkg::REQ_TDATA_W-1:0]    req_tdata = '0;
   // operation, zero fill
   logic [swsnd_pkg::REQ_TUSER_W-1:0]    req_tuser = '0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   // send_accepted, data_seq, acked_count, timeout_fired, timeout_start,
   // timeout_end, window_base, window_next, tx_total, rx_total,
   // timeout_total, all_done, zero fill
   logic [swsnd_pkg::RSP_TDATA_W-1:0]    rsp_tdata;
   logic                                 csr_wr_en = 1'b0;
   logic [swsnd_pkg::CSR_INDEX_W-1:0]    csr_index = '0;
   logic [W-1:0]                         csr_wdata = '0;

   sliding_window_sender u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // window mirror
   logic                            slot_busy  [DEPTH];
   logic [W-1:0]                    slot_seqno [DEPTH];
   logic [W-1:0]                    slot_stamp [DEPTH];
   logic [W-1:0]                    base_seq = '0;
   logic [W-1:0]                    head_seq = '0;
   logic [W-1:0]                    tick_now = '0;
   logic [W-1:0]                    tx_cnt = '0;
   logic [W-1:0]                    rx_cnt = '0;
   logic [W-1:0]                    tmo_cnt = '0;
   logic [W-1:0]                    lost_start = '0;
   logic [W-1:0]                    lost_end = '0;
   int unsigned                     base_ptr = 0;
   int unsigned                     next_ptr = 0;
   logic [swsnd_pkg::WIN_W-1:0]     cfg_window = swsnd_pkg::WINDOW_SLOTS_RST;
   logic [swsnd_pkg::TMO_W-1:0]     cfg_timeout = swsnd_pkg::TIMEOUT_TICKS_RST;
   logic [W-1:0]                    cfg_total = swsnd_pkg::TOTAL_REQUESTS_RST;

   swsnd_pkg::rsp_type expected_status_q [$];
   int                 fail_count = 0;
   int                 quiet_cycles = 0;
   int                 burst_left = 0;
   int                 flow_span = 0;
   flow_mode_type      flow_mode = FLOW_OPEN;

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_busy[i] = 1'b0;
         slot_seqno[i] = '0;
         slot_stamp[i] = '0;
      end
   end

   function automatic int unsigned used_slots();
      int unsigned w;
      w = 32'(cfg_window);
      if (w == 0) w = 1;
      if (w > DEPTH) w = DEPTH;
      return w;
   endfunction

   function automatic int unsigned step_ptr(input int unsigned p);
      return (p + 1 >= used_slots()) ? 0 : p + 1;
   endfunction

   function automatic void free_slot(input int unsigned p, input logic [W-1:0] seq);
      if (slot_busy[p] && slot_seqno[p] == seq) slot_busy[p] = 1'b0;
   endfunction

   task automatic predict_status(input logic [swsnd_pkg::OP_W-1:0] op,
                                 input logic [W-1:0] kind,
                                 input logic [W-1:0] num, input logic [W-1:0] len,
                                 output swsnd_pkg::rsp_type r);
      logic [W-1:0] ack_top;
      logic [W-1:0] elapsed;
      logic [W-1:0] s;
      int unsigned  p;
      int           acked;
      logic         expire;
      acked = 0;
      r = '0;
      case (op)
         swsnd_pkg::OP_SEND: begin
            if (head_seq < cfg_total && (head_seq - base_seq) < used_slots()) begin
               slot_busy[next_ptr] = 1'b1;
               slot_seqno[next_ptr] = head_seq;
               slot_stamp[next_ptr] = tick_now;
               r.send_accepted = 1'b1;
               r.data_seq = head_seq;
               tx_cnt++;
               head_seq++;
               next_ptr = step_ptr(next_ptr);
            end
         end
         swsnd_pkg::OP_ACK: begin
            if (kind == swsnd_pkg::ACK_KIND && len == 0 && num != swsnd_pkg::NO_SEQ &&
                base_seq != head_seq && num >= base_seq) begin
               ack_top = (num >= head_seq) ? head_seq - W'(1) : num;
               while (base_seq <= ack_top) begin
                  free_slot(base_ptr, base_seq);
                  base_seq++;
                  base_ptr = step_ptr(base_ptr);
                  acked++;
               end
               rx_cnt += W'(acked);
            end
         end
         swsnd_pkg::OP_TICK: begin
            tick_now++;
            if (base_seq != head_seq) begin
               elapsed = tick_now - slot_stamp[base_ptr];
               expire = !(slot_busy[base_ptr] && slot_seqno[base_ptr] == base_seq &&
                          elapsed < W'(cfg_timeout));
               if (expire) begin
                  tmo_cnt++;
                  lost_start = base_seq;
                  lost_end = head_seq;
                  s = base_seq;
                  p = base_ptr;
                  while (s != head_seq) begin
                     free_slot(p, s);
                     s++;
                     p = step_ptr(p);
                  end
                  base_seq = head_seq;
                  base_ptr = next_ptr;
                  r.timeout_fired = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.acked_count = swsnd_pkg::ACK_W'(acked);
      r.timeout_start = lost_start;
      r.timeout_end = lost_end;
      r.window_base = base_seq;
      r.window_next = head_seq;
      r.tx_total = tx_cnt;
      r.rx_total = rx_cnt;
      r.timeout_total = tmo_cnt;
      r.all_done = (head_seq >= cfg_total && base_seq == head_seq);
   endtask

   task automatic send_item(input logic [swsnd_pkg::OP_W-1:0] op, input logic [W-1:0] kind,
                            input logic [W-1:0] num, input logic [W-1:0] len);
      swsnd_pkg::rsp_type want;
      int                 gap;
      gap = 0;
      req_tvalid <= 1'b1;
      req_tdata <= {len, num, kind};
      req_tuser <= swsnd_pkg::REQ_TUSER_W'(op);
      do @(posedge clock); while (!req_tready);
      predict_status(op, kind, num, len, want);
      expected_status_q.push_back(want);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
      end else begin
         burst_left--;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_responses();
      if (req_tvalid) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_register(input logic [swsnd_pkg::CSR_INDEX_W-1:0] idx,
                               input logic [W-1:0] val);
      drain_responses();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         swsnd_pkg::CSR_WINDOW_SLOTS:   cfg_window = val[swsnd_pkg::WIN_W-1:0];
         swsnd_pkg::CSR_TIMEOUT_TICKS:  cfg_timeout = val[swsnd_pkg::TMO_W-1:0];
         swsnd_pkg::CSR_TOTAL_REQUESTS: cfg_total = val;
         default: ;
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_ack(input logic [W-1:0] num);
      send_item(swsnd_pkg::OP_ACK, swsnd_pkg::ACK_KIND, num, '0);
   endtask

   task automatic test_idle_status();
      send_item(OP_NOP, '1, '1, '1);
      send_item(swsnd_pkg::OP_TICK, '0, '0, '0);
      send_ack(0);
   endtask

   task automatic test_send_and_ack();
      repeat (4) send_item(swsnd_pkg::OP_SEND, $urandom, $urandom, $urandom);
      send_item(swsnd_pkg::OP_ACK, '0, 1, '0);
      send_item(swsnd_pkg::OP_ACK, '1, 1, '0);
      send_item(swsnd_pkg::OP_ACK, swsnd_pkg::ACK_KIND, 1, '1);
      send_ack(swsnd_pkg::NO_SEQ);
      send_ack(1);
      send_ack(0);
      send_ack(32'hFFFF_FFFE);
   endtask

   task automatic test_window_limits();
      set_register(swsnd_pkg::CSR_WINDOW_SLOTS, 1);
      send_item(swsnd_pkg::OP_SEND, '0, '0, '0);
      send_item(swsnd_pkg::OP_SEND, '0, '0, '0);
      set_register(swsnd_pkg::CSR_WINDOW_SLOTS, 0);
      send_item(swsnd_pkg::OP_SEND, '0, '0, '0);
      send_ack(head_seq - W'(1));
      send_item(swsnd_pkg::OP_SEND, '0, '0, '0);
      send_ack(head_seq);
   endtask

   task automatic test_request_budget();
      set_register(swsnd_pkg::CSR_TOTAL_REQUESTS, head_seq + W'(1));
      send_item(swsnd_pkg::OP_SEND, '0, '0, '0);
      send_item(swsnd_pkg::OP_SEND, '0, '0, '0);
      send_ack(head_seq);
      set_register(swsnd_pkg::CSR_TOTAL_REQUESTS, 0);
      send_item(swsnd_pkg::OP_SEND, '0, '0, '0);
      set_register(swsnd_pkg::CSR_TOTAL_REQUESTS, '1);
   endtask

   task automatic test_timeouts();
      set_register(swsnd_pkg::CSR_WINDOW_SLOTS, 32);
      set_register(swsnd_pkg::CSR_TIMEOUT_TICKS, 0);
      send_item(swsnd_pkg::OP_SEND, '0, '0, '0);
      send_item(swsnd_pkg::OP_TICK, '0, '0, '0);
      set_register(swsnd_pkg::CSR_TIMEOUT_TICKS, 2);
      send_item(swsnd_pkg::OP_SEND, '0, '0, '0);
      send_item(swsnd_pkg::OP_SEND, '0, '0, '0);
      send_item(swsnd_pkg::OP_TICK, '0, '0, '0);
      send_item(swsnd_pkg::OP_TICK, '0, '0, '0);
      set_register(swsnd_pkg::CSR_TIMEOUT_TICKS, 32'h0000_FFFF);
      send_item(swsnd_pkg::OP_SEND, '0, '0, '0);
      send_item(swsnd_pkg::OP_TICK, '0, '0, '0);
      send_ack(head_seq);
   endtask

   task automatic random_item();
      logic [W-1:0] span;
      logic [W-1:0] num;
      int           pick;
      pick = $urandom_range(0, 99);
      span = head_seq - base_seq;
      if (pick < 42) begin
         send_item(swsnd_pkg::OP_SEND, $urandom, $urandom, $urandom);
      end else if (pick < 72) begin
         if ($urandom_range(0, 7) == 0) num = base_seq - W'(1);
         else num = base_seq + $urandom_range(0, span + 2);
         send_ack(num);
      end else if (pick < 90) begin
         send_item(swsnd_pkg::OP_TICK, $urandom, $urandom, $urandom);
      end else if (pick < 94) begin
         send_item(OP_NOP, $urandom, $urandom, $urandom);
      end else begin
         case ($urandom_range(0, 2))
            0: send_item(swsnd_pkg::OP_ACK, $urandom, base_seq, '0);
            1: send_item(swsnd_pkg::OP_ACK, swsnd_pkg::ACK_KIND, base_seq,
                         1 << $urandom_range(0, 31));
            default: send_item(swsnd_pkg::OP_ACK,
                               $urandom_range(0, 1) ? swsnd_pkg::ACK_KIND : $urandom,
                               $urandom, $urandom_range(0, 1) ? '0 : $urandom);
         endcase
      end
   endtask

   task automatic test_random_traffic();
      logic [swsnd_pkg::WIN_W-1:0] windows [PHASES] =
         '{6'd1, 6'd32, 6'd0, 6'd63, 6'd5, 6'd2, 6'd8, 6'd20};
      logic [swsnd_pkg::TMO_W-1:0] timeouts [PHASES] =
         '{16'd1, 16'd0, 16'd3, 16'hFFFF, 16'd2, 16'd6, 16'd5, 16'd4};
      logic [W-1:0] total;
      for (int k = 0; k < PHASES; k++) begin
         if (k == 6) windows[k] = swsnd_pkg::WIN_W'($urandom_range(1, 40));
         if (k == 3) total = head_seq + W'(10);
         else if (k == 6) total = '1;
         else total = head_seq + $urandom_range(30, 120);
         set_register(swsnd_pkg::CSR_WINDOW_SLOTS, W'(windows[k]));
         set_register(swsnd_pkg::CSR_TIMEOUT_TICKS, W'(timeouts[k]));
         set_register(swsnd_pkg::CSR_TOTAL_REQUESTS, total);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) drain_responses();
            random_item();
         end
      end
   endtask

   task automatic check_field(input string name, input logic [W-1:0] want,
                              input logic [W-1:0] got, inout logic bad);
      if (want !== got) begin
         if (fail_count < 10)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
         bad = 1'b1;
      end
   endtask

   always @(posedge clock) begin : check_rsp
      swsnd_pkg::rsp_type got;
      swsnd_pkg::rsp_type want;
      logic               bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = swsnd_pkg::rsp_type'(rsp_tdata[swsnd_pkg::RSP_W-1:0]);
         bad = 1'b0;
         if (expected_status_q.size() == 0) begin
            if (fail_count < 10) $display("%0t: response beat with none pending", $realtime);
            fail_count++;
         end else begin
            want = expected_status_q.pop_front();
            check_field("send_accepted", W'(want.send_accepted), W'(got.send_accepted), bad);
            check_field("data_seq", want.data_seq, got.data_seq, bad);
            check_field("acked_count", W'(want.acked_count), W'(got.acked_count), bad);
            check_field("timeout_fired", W'(want.timeout_fired), W'(got.timeout_fired), bad);
            check_field("timeout_start", want.timeout_start, got.timeout_start, bad);
            check_field("timeout_end", want.timeout_end, got.timeout_end, bad);
            check_field("window_base", want.window_base, got.window_base, bad);
            check_field("window_next", want.window_next, got.window_next, bad);
            check_field("tx_total", want.tx_total, got.tx_total, bad);
            check_field("rx_total", want.rx_total, got.rx_total, bad);
            check_field("timeout_total", want.timeout_total, got.timeout_total, bad);
            check_field("all_done", W'(want.all_done), W'(got.all_done), bad);
            if (bad) fail_count++;
         end
      end
   end

   always @(posedge clock) begin
      if (flow_span == 0) begin
         flow_span = $urandom_range(1, 40);
         flow_mode = flow_mode_type'($urandom_range(0, 2));
      end else begin
         flow_span--;
      end
      case (flow_mode)
         FLOW_OPEN:    rsp_tready <= 1'b1;
         FLOW_PATCHY:  rsp_tready <= ($urandom_range(0, 3) != 0);
         default:      rsp_tready <= 1'b0;
      endcase
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_status();
      test_send_and_ack();
      test_window_limits();
      test_request_budget();
      test_timeouts();
      test_random_traffic();
      drain_responses();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && expected_status_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
